// ===== sv/itp_pkg.sv =====
// shared types, constants and helper functions of the infix to postfix converter
`timescale 1ns / 1ps

package itp_pkg;

    // operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

    // queue geometry (power-of-two depths)
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // ascii codes the converter recognizes
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // operator codes held on the stack
    typedef enum logic [2:0] {
        OP_LPAR = 3'd0,
        OP_POW  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_ADD  = 3'd4,
        OP_SUB  = 3'd5
    } t_op_code;

    // character classes found by the front end
    typedef enum logic [2:0] {
        K_IGNORE = 3'd0,
        K_ALNUM  = 3'd1,
        K_LPAR   = 3'd2,
        K_RPAR   = 3'd3,
        K_OP     = 3'd4
    } t_kind;

    // engine sequencer states
    typedef enum logic {
        ST_MAIN  = 1'b0,
        ST_FLUSH = 1'b1
    } t_eng_state;

    // classified item passed from front end to engine
    typedef struct packed {
        t_kind      kind;
        t_op_code   code;
        logic [7:0] ch;
        logic       last;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       expr_done;
        logic       stack_overflow;
    } t_result;

    // operator precedence
    function automatic logic [1:0] op_prec(input t_op_code code);
        logic [1:0] p;
        case (code)
            OP_POW:  p = 2'd3;
            OP_MUL:  p = 2'd2;
            OP_DIV:  p = 2'd2;
            OP_ADD:  p = 2'd1;
            OP_SUB:  p = 2'd1;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // character printed for a popped stack entry
    function automatic logic [7:0] op_char(input t_op_code code);
        logic [7:0] c;
        case (code)
            OP_LPAR: c = CH_LPAR;
            OP_POW:  c = CH_POW;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // sort an incoming character into its class
    function automatic t_cmd classify(input logic [7:0] ch, input logic last);
        t_cmd c;
        c.kind = K_IGNORE;
        c.code = OP_LPAR;
        c.ch   = ch;
        c.last = last;
        if ((ch >= CH_DIG_0 && ch <= CH_DIG_9) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
            (ch >= CH_LO_A && ch <= CH_LO_Z)) begin
            c.kind = K_ALNUM;
        end else begin
            case (ch)
                CH_LPAR: c.kind = K_LPAR;
                CH_RPAR: c.kind = K_RPAR;
                CH_POW: begin
                    c.kind = K_OP;
                    c.code = OP_POW;
                end
                CH_MUL: begin
                    c.kind = K_OP;
                    c.code = OP_MUL;
                end
                CH_DIV: begin
                    c.kind = K_OP;
                    c.code = OP_DIV;
                end
                CH_ADD: begin
                    c.kind = K_OP;
                    c.code = OP_ADD;
                end
                CH_SUB: begin
                    c.kind = K_OP;
                    c.code = OP_SUB;
                end
                default: c.kind = K_IGNORE;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== sv/itp_front.sv =====
// front end: classifies input characters and queues them for the engine
`timescale 1ns / 1ps

module itp_front
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_char,
    input  logic       i_expr_end,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_cnt;
    logic               wr_en;
    logic               rd_en;

    // handshake qualifiers
    assign o_full      = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd_ptr];

    // queue storage, classified on the way in
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= classify(i_in_char, i_expr_end);
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + CMDQ_CW'(1);
                2'b01:   r_cnt <= r_cnt - CMDQ_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/itp_engine.sv =====
// back end: operator stack sequencer that produces postfix result items
`timescale 1ns / 1ps

module itp_engine
    import itp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_wr,
    output t_result o_res
);

    localparam logic [STK_CW-1:0] CNT_ONE  = STK_CW'(1);
    localparam logic [STK_CW-1:0] CNT_TWO  = STK_CW'(2);
    localparam logic [STK_CW-1:0] CNT_FULL = STK_CW'(STACK_DEPTH);

    t_op_code          r_stack [STACK_DEPTH];
    t_eng_state        r_state;
    t_eng_state        n_state;
    logic [STK_CW-1:0] r_count;
    logic [STK_CW-1:0] n_count;
    t_op_code          r_top;
    t_op_code          n_top;
    t_op_code          r_below;
    logic              r_ovf;
    logic              n_ovf;
    logic              r_emitted;
    logic              n_emitted;

    logic              active;
    logic              stk_nonempty;
    logic              more_one;
    logic              more_two;
    logic              top_lpar;
    logic              below_lpar;
    logic              do_push;
    logic              do_pop;
    t_op_code          push_code;
    logic              emit;
    logic              emit_valid;
    logic [7:0]        emit_char;
    logic              follows;
    logic              done_main;
    logic              finish;
    logic [STK_CW-1:0] rd_off;
    logic [STK_AW-1:0] rd_addr;

    // stack view: r_top is the top entry, r_below the one under it
    assign active       = i_cmd_valid && !i_res_full;
    assign stk_nonempty = (r_count != '0);
    assign more_one     = (r_count > CNT_ONE);
    assign more_two     = (r_count > CNT_TWO);
    assign top_lpar     = (r_top == OP_LPAR);
    assign below_lpar   = (r_below == OP_LPAR);

    // action decode for the current cycle
    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        push_code  = OP_LPAR;
        emit       = 1'b0;
        emit_valid = 1'b0;
        emit_char  = CH_NUL;
        follows    = 1'b0;
        done_main  = 1'b0;
        finish     = 1'b0;
        case (r_state)
            ST_MAIN: begin
                case (i_cmd.kind)
                    K_ALNUM: begin
                        emit       = 1'b1;
                        emit_valid = 1'b1;
                        emit_char  = i_cmd.ch;
                        follows    = i_cmd.last && stk_nonempty;
                        done_main  = 1'b1;
                    end
                    K_LPAR: begin
                        do_push   = 1'b1;
                        push_code = OP_LPAR;
                        done_main = 1'b1;
                    end
                    K_RPAR: begin
                        if (stk_nonempty && !top_lpar) begin
                            do_pop     = 1'b1;
                            emit       = 1'b1;
                            emit_valid = 1'b1;
                            emit_char  = op_char(r_top);
                            follows    = (more_one && !below_lpar) ||
                                         (i_cmd.last && more_two);
                        end else begin
                            // drop the matching open paren if there is one
                            do_pop    = stk_nonempty;
                            done_main = 1'b1;
                        end
                    end
                    K_OP: begin
                        if (stk_nonempty && !top_lpar &&
                            op_prec(r_top) >= op_prec(i_cmd.code)) begin
                            do_pop     = 1'b1;
                            emit       = 1'b1;
                            emit_valid = 1'b1;
                            emit_char  = op_char(r_top);
                            follows    = i_cmd.last ||
                                         (more_one && !below_lpar &&
                                          op_prec(r_below) >= op_prec(i_cmd.code));
                        end else begin
                            do_push   = 1'b1;
                            push_code = i_cmd.code;
                            done_main = 1'b1;
                        end
                    end
                    default: done_main = 1'b1;
                endcase
                finish = done_main && !i_cmd.last;
            end
            ST_FLUSH: begin
                if (stk_nonempty) begin
                    do_pop     = 1'b1;
                    emit       = 1'b1;
                    emit_valid = 1'b1;
                    emit_char  = op_char(r_top);
                    follows    = more_one;
                end else begin
                    // an expression end with no result so far still yields one marker item
                    emit   = !r_emitted;
                    finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_MAIN: begin
                if (active && done_main && i_cmd.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (active && finish) begin
                    n_state = ST_MAIN;
                end
            end
            default: n_state = ST_MAIN;
        endcase
    end

    // stack pointer, top and flags
    always_comb begin
        n_count   = r_count;
        n_top     = r_top;
        n_ovf     = r_ovf;
        n_emitted = r_emitted;
        if (active) begin
            if (do_push) begin
                if (r_count == CNT_FULL) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CNT_ONE;
                    n_top   = push_code;
                end
            end
            if (do_pop) begin
                n_count = r_count - CNT_ONE;
                n_top   = r_below;
            end
            if (emit) begin
                n_emitted = 1'b1;
            end
            if (finish) begin
                n_emitted = 1'b0;
                if (i_cmd.last) begin
                    n_ovf = 1'b0;
                end
            end
        end
    end

    // prefetch address of the entry under the next top
    assign rd_off  = (n_count > CNT_ONE) ? (n_count - CNT_TWO) : '0;
    assign rd_addr = rd_off[STK_AW-1:0];

    // stack memory
    always_ff @(posedge i_clk) begin
        if (active && do_push && r_count != CNT_FULL) begin
            r_stack[r_count[STK_AW-1:0]] <= push_code;
        end
        r_below <= r_stack[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_MAIN;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_emitted <= n_emitted;
        end
    end

    // top entry register
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // result item and queue handshakes
    assign o_cmd_pop            = active && finish;
    assign o_res_wr             = active && emit;
    assign o_res.out_char       = emit_char;
    assign o_res.char_valid     = emit_valid;
    assign o_res.run_last       = !follows;
    assign o_res.expr_done      = !follows && i_cmd.last;
    assign o_res.stack_overflow = r_ovf;

`ifndef NO_ASSERTIONS
    // stack never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("operator stack count beyond depth");

    // flushing only happens for an item that ends the expression
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (i_cmd_valid && i_cmd.last))
        else $error("flush without expression end");

    // expression done only on an item that ends the expression
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.expr_done) |-> i_cmd.last)
        else $error("expression done on a non-final item");

    // each flushed character removes one stack entry
    a_flush_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.char_valid && r_state == ST_FLUSH)
        |=> (r_count == $past(r_count) - CNT_ONE))
        else $error("flush emitted without popping");
`endif

endmodule

// ===== sv/itp_res_queue.sv =====
// result queue between the engine and the output port
`timescale 1ns / 1ps

module itp_res_queue
    import itp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    t_result            r_mem [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr_ptr;
    logic [RESQ_AW-1:0] r_rd_ptr;
    logic [RESQ_CW-1:0] r_cnt;
    logic               wr_en;
    logic               rd_en;

    // handshake qualifiers
    assign o_full  = (r_cnt == RESQ_CW'(RESQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + RESQ_AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + RESQ_AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + RESQ_CW'(1);
                2'b01:   r_cnt <= r_cnt - RESQ_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/infix_to_postfix_converter_core.sv =====
// top level of the shunting-yard infix to postfix converter
`timescale 1ns / 1ps

// Characters enter through a queue-style port: an item is taken when push is
// high and full is low; i_expr_end marks the last character of an expression.
// Results leave through a queue-style port: the oldest result sits on the o_
// result ports while empty is low and is taken when pop is high.
// A classifying front end feeds a two-entry command queue; the stack engine
// drains it and writes a four-entry result queue, so both sides stall apart.
// The engine emits a letter or digit, drops an ignored character, pushes a
// '(', pops and emits stacked operators of equal or higher precedence before
// pushing an operator, for a ')' pops and emits down to its '(' and drops
// that '(' if present, and at expression end flushes all entries left and
// closes. The operator stack is a memory with one registered read port, the
// prefetched entry under the top.
// Reset empties both queues, the stack and the overflow flag at once.
// When the receiver stops popping, the result queue fills, the engine holds,
// and full rises once the command queue is also full.

module infix_to_postfix_converter_core
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_expr_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_run_last,
    output logic       o_expr_done,
    output logic       o_stack_overflow
);

    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    logic    res_full;
    logic    res_wr;
    t_result res_in;
    t_result res_out;

    // character classification and command queue
    itp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_char   (i_in_char),
        .i_expr_end  (i_expr_end),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // operator stack engine
    itp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (res_in)
    );

    // result queue
    itp_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res_in),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    // result fields
    assign o_out_char       = res_out.out_char;
    assign o_char_valid     = res_out.char_valid;
    assign o_run_last       = res_out.run_last;
    assign o_expr_done      = res_out.expr_done;
    assign o_stack_overflow = res_out.stack_overflow;

endmodule

// ===== tb/tb_infix_to_postfix_converter_core.sv =====
// self-checking testbench for the infix to postfix converter core
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_core;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 105;
    localparam int MAX_REPORTS  = 30;

    // tracks the operator stack and holds the postfix characters still owed
    class postfix_tracker;
        t_op_code opstk[STACK_DEPTH];
        int       depth;
        bit       ovf;
        t_result  step_out[$];
        t_result  postfix_q[$];
        int       errors;
        int       n_items;
        int       n_results;
        int       n_ends;
        int       n_ovf;

        function new();
            depth     = 0;
            ovf       = 1'b0;
            errors    = 0;
            n_items   = 0;
            n_results = 0;
            n_ends    = 0;
            n_ovf     = 0;
        endfunction

        function bit is_alnum(logic [7:0] ch);
            return (ch >= CH_DIG_0 && ch <= CH_DIG_9) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
                   (ch >= CH_LO_A && ch <= CH_LO_Z);
        endfunction

        // operator character to stack code
        function bit op_of(logic [7:0] ch, output t_op_code c);
            c = OP_LPAR;
            case (ch)
                CH_POW:  c = OP_POW;
                CH_MUL:  c = OP_MUL;
                CH_DIV:  c = OP_DIV;
                CH_ADD:  c = OP_ADD;
                CH_SUB:  c = OP_SUB;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function bit is_meaningful(logic [7:0] ch);
            t_op_code c;
            return is_alnum(ch) || ch == CH_LPAR || ch == CH_RPAR || op_of(ch, c);
        endfunction

        function int rank(t_op_code c);
            if (c == OP_POW) return 3;
            if (c == OP_MUL || c == OP_DIV) return 2;
            if (c == OP_ADD || c == OP_SUB) return 1;
            return 0;
        endfunction

        function logic [7:0] glyph(t_op_code c);
            case (c)
                OP_POW:  return CH_POW;
                OP_MUL:  return CH_MUL;
                OP_DIV:  return CH_DIV;
                OP_ADD:  return CH_ADD;
                OP_SUB:  return CH_SUB;
                default: return CH_LPAR;
            endcase
        endfunction

        function void put(logic [7:0] ch, logic valid);
            t_result r;
            r.out_char       = valid ? ch : CH_NUL;
            r.char_valid     = valid;
            r.run_last       = 1'b0;
            r.expr_done      = 1'b0;
            r.stack_overflow = ovf;
            if (ovf) n_ovf++;
            step_out.push_back(r);
        endfunction

        function void pop_out();
            depth--;
            put(glyph(opstk[depth]), 1'b1);
        endfunction

        // a push onto a full stack is dropped and remembered
        function void push_op(t_op_code c);
            if (depth >= STACK_DEPTH) begin
                ovf = 1'b1;
            end else begin
                opstk[depth] = c;
                depth++;
            end
        endfunction

        // accepted input item: work out the postfix characters it releases
        function void note_char(logic [7:0] ch, logic last);
            t_op_code c;
            bit       is_op;
            step_out.delete();
            n_items++;
            is_op = op_of(ch, c);
            if (is_alnum(ch)) begin
                put(ch, 1'b1);
            end else if (ch == CH_LPAR) begin
                push_op(OP_LPAR);
            end else if (ch == CH_RPAR) begin
                while (depth > 0 && opstk[depth-1] != OP_LPAR) pop_out();
                if (depth > 0) depth--;
            end else if (is_op) begin
                while (depth > 0 && opstk[depth-1] != OP_LPAR &&
                       rank(opstk[depth-1]) >= rank(c)) pop_out();
                push_op(c);
            end
            // expression end flushes the whole stack, open parens included
            if (last) begin
                while (depth > 0) pop_out();
                if (step_out.size() == 0) put(CH_NUL, 1'b0);
                step_out[step_out.size()-1].expr_done = 1'b1;
                ovf = 1'b0;
                n_ends++;
            end
            if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
            foreach (step_out[i]) postfix_q.push_back(step_out[i]);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
            errors++;
        endtask

        // compare a popped result with the oldest owed character
        task check_result(t_result got);
            t_result e;
            n_results++;
            if (postfix_q.size() == 0) begin
                report($sformatf("result char %h with nothing expected", got.out_char));
            end else begin
                e = postfix_q.pop_front();
                if (got.out_char !== e.out_char)
                    report($sformatf("out_char got %h exp %h", got.out_char, e.out_char));
                if (got.char_valid !== e.char_valid)
                    report($sformatf("char_valid got %b exp %b", got.char_valid, e.char_valid));
                if (got.run_last !== e.run_last)
                    report($sformatf("run_last got %b exp %b", got.run_last, e.run_last));
                if (got.expr_done !== e.expr_done)
                    report($sformatf("expr_done got %b exp %b", got.expr_done, e.expr_done));
                if (got.stack_overflow !== e.stack_overflow)
                    report($sformatf("stack_overflow got %b exp %b",
                                     got.stack_overflow, e.stack_overflow));
            end
        endtask

        task check_leftovers();
            while (postfix_q.size() > 0) begin
                report($sformatf("expected char %h never came", postfix_q[0].out_char));
                void'(postfix_q.pop_front());
            end
        endtask

        function int pending();
            return postfix_q.size();
        endfunction
    endclass

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       push             = 1'b0;
    logic [7:0] i_in_char        = 8'h00;
    logic       i_expr_end       = 1'b0;
    logic       pop              = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_run_last;
    logic       o_expr_done;
    logic       o_stack_overflow;

    postfix_tracker sb = new();
    t_in_item       char_q[$];
    logic [7:0]     expr_buf[$];
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             budget;
    int             cycles         = 0;

    infix_to_postfix_converter_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_char        (i_in_char),
        .i_expr_end       (i_expr_end),
        .empty            (empty),
        .pop              (pop),
        .o_out_char       (o_out_char),
        .o_char_valid     (o_char_valid),
        .o_run_last       (o_run_last),
        .o_expr_done      (o_expr_done),
        .o_stack_overflow (o_stack_overflow)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // sender: an item stays on the port until it is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.note_char(i_in_char, i_expr_end);
                void'(char_q.pop_front());
            end
            if (char_q.size() > 0 &&
                ((push && full) || $urandom_range(99) >= send_idle_pct)) begin
                push       <= 1'b1;
                i_in_char  <= char_q[0].ch;
                i_expr_end <= char_q[0].last;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver: check each popped result, stall at random
    always @(posedge i_clk) begin : recv
        t_result got;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got.out_char       = o_out_char;
                got.char_valid     = o_char_valid;
                got.run_last       = o_run_last;
                got.expr_done      = o_expr_done;
                got.stack_overflow = o_stack_overflow;
                sb.check_result(got);
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // queue one item; ignored characters count toward the budget only when they end an expression
    task add_char(logic [7:0] ch, logic last);
        t_in_item it;
        it.ch   = ch;
        it.last = last;
        char_q.push_back(it);
        if (last || sb.is_meaningful(ch)) budget++;
    endtask

    task add_text(string s, logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], last_on_end && (i == s.len() - 1));
    endtask

    function logic [7:0] pick_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 10) return CH_DIG_0 + 8'(r);
        if (r < 36) return CH_UP_A + 8'(r - 10);
        return CH_LO_A + 8'(r - 36);
    endfunction

    function logic [7:0] pick_op();
        case ($urandom_range(4))
            0:       return CH_POW;
            1:       return CH_MUL;
            2:       return CH_DIV;
            3:       return CH_ADD;
            default: return CH_SUB;
        endcase
    endfunction

    // move the built expression into the item queue, end flag on its last char
    task flush_expr();
        foreach (expr_buf[i]) add_char(expr_buf[i], i == expr_buf.size() - 1);
        expr_buf.delete();
    endtask

    task automatic build_operand(int lvl);
        if (lvl > 0 && $urandom_range(3) == 0) begin
            expr_buf.push_back(CH_LPAR);
            build_sum(lvl - 1);
            expr_buf.push_back(CH_RPAR);
        end else begin
            expr_buf.push_back(pick_alnum());
        end
    endtask

    // well-formed expression, a space now and then
    task automatic build_sum(int lvl);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if (i > 0) expr_buf.push_back(pick_op());
            if ($urandom_range(9) == 0) expr_buf.push_back(8'h20);
            build_operand(lvl);
        end
    endtask

    // random tokens: unbalanced parens, stray operators
    task build_broken();
        int n;
        n = $urandom_range(3, 10);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0:       expr_buf.push_back(pick_alnum());
                1:       expr_buf.push_back(pick_op());
                2:       expr_buf.push_back(CH_LPAR);
                default: expr_buf.push_back(CH_RPAR);
            endcase
        end
    endtask

    // deep nesting, often past the stack depth
    task build_deep();
        int n;
        n = $urandom_range(28, 38);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                expr_buf.push_back(pick_alnum());
                expr_buf.push_back(pick_op());
            end
            expr_buf.push_back(CH_LPAR);
        end
        expr_buf.push_back(pick_alnum());
        n = $urandom_range(0, n);
        for (int i = 0; i < n; i++) expr_buf.push_back(CH_RPAR);
    endtask

    task add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_char(8'($urandom_range(255)), $urandom_range(3) == 0);
    endtask

    // hold the sender until the core has handed back everything
    task wait_drained();
        while (char_q.size() != 0 || push || sb.pending() != 0) @(posedge i_clk);
    endtask

    task run_random_phase();
        int  r;
        bit  deep_done;
        budget    = 0;
        deep_done = 1'b0;
        @(negedge i_clk);
        while (budget < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (!deep_done && (r < 4 || budget > 30)) begin
                build_deep();
                flush_expr();
                deep_done = 1'b1;
            end else if (r < 80) begin
                build_sum(3);
                flush_expr();
            end else if (r < 90) begin
                build_broken();
                flush_expr();
            end else begin
                add_noise();
            end
        end
        wait_drained();
    endtask

    // main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every operator, left-assoc power, unmatched ')', leftover '(',
        // ignored chars at both ends of the byte range, empty expression
        @(negedge i_clk);
        add_text("A+b*c^d", 1'b1);
        add_text("x/y-Z", 1'b1);
        add_text("0^9^z", 1'b1);
        add_text("a-b)", 1'b1);
        add_text("(9", 1'b1);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        wait_drained();

        // no idling, then sender idle, receiver stall, both
        run_random_phase();
        send_idle_pct = 78;
        run_random_phase();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random_phase();
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_random_phase();

        recv_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftovers();

        $display("covered %0d items and %0d results over %0d expressions",
                 sb.n_items, sb.n_results, sb.n_ends);
        $display("stack overflow flagged on %0d results, %0d mismatches",
                 sb.n_ovf, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/itp_pkg.sv
sv/itp_front.sv
sv/itp_engine.sv
sv/itp_res_queue.sv
sv/infix_to_postfix_converter_core.sv
tb/tb_infix_to_postfix_converter_core.sv
